// ----- rtl/core/mpbm_pkg.sv -----
// ---------------------------------------------------------------------------
// Multi-pattern byte matcher package
// Shared types, operation and status codes, and default sizes.
// ---------------------------------------------------------------------------
package mpbm_pkg;

   localparam int MPBM_NODE_COUNT       = 256;
   localparam int MPBM_SYMBOL_COUNT     = 256;
   localparam int MPBM_MATCHES_PER_NODE = 4;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_REWIND = 3'd1;
   localparam logic [2:0] OP_ADD    = 3'd2;
   localparam logic [2:0] OP_CLOSE  = 3'd3;
   localparam logic [2:0] OP_BUILD  = 3'd4;
   localparam logic [2:0] OP_SEARCH = 3'd5;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NODE_FULL  = 2'd1;
   localparam logic [1:0] STATUS_MATCH_FULL = 2'd2;

   localparam logic CSR_FOLD_CASE = 1'b0;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] symbol;
      logic [7:0] pattern_length;
   } req_payload_type;

   typedef struct packed {
      logic        match_found;
      logic [7:0]  match_length;
      logic [31:0] match_start;
      logic [7:0]  node_now;
      logic [1:0]  status_code;
      logic        last_result;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_LK,
      ST_WAIT,
      ST_ADD_DEC,
      ST_SR_DEC,
      ST_SR_FAIL,
      ST_SR_CNT,
      ST_SR_CNTQ,
      ST_SR_MATCH,
      ST_LA_CNT,
      ST_LA_SCAN,
      ST_LA_CMP,
      ST_LA_APP,
      ST_BL_DEC,
      ST_BL_NEXT,
      ST_BL_POP,
      ST_BL_POPQ,
      ST_BL_CSF,
      ST_BL_WDEC,
      ST_BL_WFAIL,
      ST_BL_ICNT,
      ST_BL_IN,
      ST_BL_ILEN,
      ST_BL_IAFTER,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/core/mpbm_trie_store.sv -----
// ---------------------------------------------------------------------------
// Trie edge store
// Goto memory plus a per-node parent record; an edge is valid only when the
// child is allocated and its parent record names the looked-up edge.
// ---------------------------------------------------------------------------
module mpbm_trie_store #(
   parameter int NODE_COUNT   = 256,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                                clock,
   input  logic [$clog2(NODE_COUNT)-1:0]       lk_node,
   input  logic [$clog2(SYMBOL_COUNT)-1:0]     lk_sym,
   input  logic                                alloc_en,
   input  logic [$clog2(NODE_COUNT)-1:0]       alloc_node,
   input  logic [$clog2(NODE_COUNT):0]         used,
   output logic [$clog2(NODE_COUNT)-1:0]       edge_node
);
   localparam int NW = $clog2(NODE_COUNT);
   localparam int SW = $clog2(SYMBOL_COUNT);
   localparam int AW = NW + SW;

   logic [NW-1:0] goto_mem [2**AW];
   logic [AW-1:0] info_mem [NODE_COUNT];

   logic [NW-1:0] goto_q_ff;
   logic [AW-1:0] key1_ff;
   logic [AW-1:0] key2_ff;
   logic [NW-1:0] g2_ff;
   logic [AW-1:0] info_q_ff;

   always_ff @(posedge clock) begin
      if (alloc_en) begin
         goto_mem[{lk_node, lk_sym}] <= alloc_node;
         info_mem[alloc_node]        <= {lk_node, lk_sym};
      end
      goto_q_ff <= goto_mem[{lk_node, lk_sym}];
      key1_ff   <= {lk_node, lk_sym};
      info_q_ff <= info_mem[goto_q_ff];
      g2_ff     <= goto_q_ff;
      key2_ff   <= key1_ff;
   end

   always_comb begin
      if ((g2_ff != '0) && ((NW+1)'(g2_ff) < used) && (info_q_ff == key2_ff)) begin
         edge_node = g2_ff;
      end else begin
         edge_node = '0;
      end
   end

endmodule

// ----- rtl/core/multi_pattern_byte_matcher_core.sv -----
// ---------------------------------------------------------------------------
// Multi-pattern byte matcher core
// Clear, rewind and unknown operations each return one result, as does add
// symbol; close pattern scans the stored lengths before it appends, and search
// follows failure links as needed, then returns one result per match. Build
// links visits every symbol of every queued node. One operation at a time.
// After reset an init state passes before start is taken. Results cannot be stalled.
// ---------------------------------------------------------------------------
module multi_pattern_byte_matcher_core
   import mpbm_pkg::*;
#(
   parameter int NODE_COUNT       = mpbm_pkg::MPBM_NODE_COUNT,
   parameter int SYMBOL_COUNT     = mpbm_pkg::MPBM_SYMBOL_COUNT,
   parameter int MATCHES_PER_NODE = mpbm_pkg::MPBM_MATCHES_PER_NODE
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mpbm_pkg::req_payload_type  req_data,
   output logic                       rsp_strobe,
   output mpbm_pkg::rsp_payload_type  rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   localparam int NW = $clog2(NODE_COUNT);
   localparam int SW = $clog2(SYMBOL_COUNT);
   localparam int MW = (MATCHES_PER_NODE > 1) ? $clog2(MATCHES_PER_NODE) : 1;
   localparam int CW = $clog2(MATCHES_PER_NODE + 1);
   localparam int UW = NW + 1;

   typedef logic [SW-1:0] sym_mod_type [256];

   function automatic sym_mod_type make_sym_mod();
      sym_mod_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = SW'(i % SYMBOL_COUNT);
      end
      return t;
   endfunction

   localparam sym_mod_type SYM_MOD = make_sym_mod();

   logic [NW-1:0]    fail_mem  [NODE_COUNT];
   logic [CW-1:0]    cnt_mem   [NODE_COUNT];
   logic [7:0]       mlen_mem  [2**(NW+MW)];
   logic [NW-1:0]    queue_mem [NODE_COUNT];

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   state_type la_ret_ff, la_ret_in;

   logic [NW-1:0] cur_ff, cur_in;
   logic [UW-1:0] used_ff, used_in;
   logic [31:0]   pos_ff, pos_in;
   logic          fold_ff, fold_in;
   logic [1:0]    status_ff, status_in;
   logic [NW-1:0] lk_node_ff, lk_node_in;
   logic [SW-1:0] lk_sym_ff, lk_sym_in;
   logic [NW-1:0] la_node_ff, la_node_in;
   logic [7:0]    la_len_ff, la_len_in;
   logic [CW-1:0] la_n_ff, la_n_in;
   logic [CW-1:0] la_k_ff, la_k_in;
   logic [SW-1:0] c_ff, c_in;
   logic [NW-1:0] head_ff, head_in;
   logic [NW-1:0] tail_ff, tail_in;
   logic [NW-1:0] cs_ff, cs_in;
   logic          root_ff, root_in;
   logic [NW-1:0] csf_ff, csf_in;
   logic [NW-1:0] nx_ff, nx_in;
   logic [NW-1:0] t_ff, t_in;
   logic [CW-1:0] in_n_ff, in_n_in;
   logic [CW-1:0] in_k_ff, in_k_in;
   logic          rsp_strobe_ff;
   rsp_payload_type rsp_data_ff;

   logic [NW-1:0]    fail_q, cnt_raddr, fail_raddr, fail_waddr, fail_wdata;
   logic [NW-1:0]    cnt_waddr, q_raddr, q_waddr, q_wdata, q_q;
   logic [CW-1:0]    cnt_q, cnt_wdata;
   logic [NW+MW-1:0] mlen_raddr, mlen_waddr;
   logic [7:0]       mlen_q, mlen_wdata;
   logic             fail_we, cnt_we, mlen_we, q_we;

   logic             alloc_en;
   logic [NW-1:0]    edge_w;
   logic             edge_nz;
   logic [CW-1:0]    la_k1_w, in_k1_w;
   logic             c_last;
   logic [7:0]       sym_fold_w;
   logic             emit_w;
   rsp_payload_type  emit_data_w;
   logic             csr_write;

   mpbm_trie_store #(
      .NODE_COUNT   (NODE_COUNT),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_trie (
      .clock      (clock),
      .lk_node    (lk_node_ff),
      .lk_sym     (lk_sym_ff),
      .alloc_en   (alloc_en),
      .alloc_node (used_ff[NW-1:0]),
      .used       (used_ff),
      .edge_node  (edge_w)
   );

   assign edge_nz  = (edge_w != '0);
   assign la_k1_w  = la_k_ff + CW'(1);
   assign in_k1_w  = in_k_ff + CW'(1);
   assign c_last   = (c_ff == SW'(SYMBOL_COUNT - 1));
   assign busy     = (state_ff != ST_IDLE);

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_FOLD_CASE) ? {31'd0, fold_ff} : 32'd0;
   assign fold_in   = (csr_write && (paddr[2] == CSR_FOLD_CASE)) ? pwdata[0] : fold_ff;

   always_comb begin
      if (fold_ff && (req_data.symbol >= 8'h61) && (req_data.symbol <= 8'h7a)) begin
         sym_fold_w = req_data.symbol - 8'h20;
      end else begin
         sym_fold_w = req_data.symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (fail_we) begin
         fail_mem[fail_waddr] <= fail_wdata;
      end
      fail_q <= fail_mem[fail_raddr];
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_q <= cnt_mem[cnt_raddr];
      if (mlen_we) begin
         mlen_mem[mlen_waddr] <= mlen_wdata;
      end
      mlen_q <= mlen_mem[mlen_raddr];
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      q_q <= queue_mem[q_raddr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.operation)
                  OP_ADD, OP_BUILD, OP_SEARCH: state_in = ST_LK;
                  OP_CLOSE:                    state_in = ST_LA_CNT;
                  default:                     state_in = ST_EMIT;
               endcase
            end
         end
         ST_LK:       state_in = ST_WAIT;
         ST_WAIT:     state_in = ret_ff;
         ST_ADD_DEC:  state_in = ST_EMIT;
         ST_SR_DEC:   state_in = (edge_nz || (lk_node_ff == '0)) ? ST_SR_CNT : ST_SR_FAIL;
         ST_SR_FAIL:  state_in = ST_LK;
         ST_SR_CNT:   state_in = ST_SR_CNTQ;
         ST_SR_CNTQ:  state_in = (cnt_q == '0) ? ST_EMIT : ST_SR_MATCH;
         ST_SR_MATCH: state_in = (la_k1_w == la_n_ff) ? ST_IDLE : ST_SR_MATCH;
         ST_LA_CNT:   state_in = ST_LA_SCAN;
         ST_LA_SCAN:  state_in = (cnt_q == '0) ? ST_LA_APP : ST_LA_CMP;
         ST_LA_CMP: begin
            if (mlen_q == la_len_ff) begin
               state_in = la_ret_ff;
            end else if (la_k1_w == la_n_ff) begin
               state_in = ST_LA_APP;
            end
         end
         ST_LA_APP:   state_in = la_ret_ff;
         ST_BL_DEC:   state_in = (edge_nz && !root_ff) ? ST_LK : ST_BL_NEXT;
         ST_BL_NEXT:  state_in = c_last ? ST_BL_POP : ST_LK;
         ST_BL_POP:   state_in = (head_ff == tail_ff) ? ST_EMIT : ST_BL_POPQ;
         ST_BL_POPQ:  state_in = ST_BL_CSF;
         ST_BL_CSF:   state_in = ST_LK;
         ST_BL_WDEC:  state_in = (edge_nz || (lk_node_ff == '0)) ? ST_BL_ICNT : ST_BL_WFAIL;
         ST_BL_WFAIL: state_in = ST_LK;
         ST_BL_ICNT:  state_in = ST_BL_IN;
         ST_BL_IN:    state_in = (cnt_q == '0) ? ST_BL_NEXT : ST_BL_ILEN;
         ST_BL_ILEN:  state_in = ST_LA_CNT;
         ST_BL_IAFTER: state_in = (in_k1_w == in_n_ff) ? ST_BL_NEXT : ST_BL_ILEN;
         ST_EMIT:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ret_in     = ret_ff;
      la_ret_in  = la_ret_ff;
      cur_in     = cur_ff;
      used_in    = used_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      lk_node_in = lk_node_ff;
      lk_sym_in  = lk_sym_ff;
      la_node_in = la_node_ff;
      la_len_in  = la_len_ff;
      la_n_in    = la_n_ff;
      la_k_in    = la_k_ff;
      c_in       = c_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cs_in      = cs_ff;
      root_in    = root_ff;
      csf_in     = csf_ff;
      nx_in      = nx_ff;
      t_in       = t_ff;
      in_n_in    = in_n_ff;
      in_k_in    = in_k_ff;

      fail_we    = 1'b0;
      fail_waddr = '0;
      fail_wdata = '0;
      fail_raddr = '0;
      cnt_we     = 1'b0;
      cnt_waddr  = '0;
      cnt_wdata  = '0;
      cnt_raddr  = '0;
      mlen_we    = 1'b0;
      mlen_waddr = '0;
      mlen_wdata = '0;
      mlen_raddr = '0;
      q_we       = 1'b0;
      q_waddr    = '0;
      q_wdata    = '0;
      q_raddr    = '0;
      alloc_en   = 1'b0;

      emit_w                   = 1'b0;
      emit_data_w.match_found  = 1'b0;
      emit_data_w.match_length = 8'd0;
      emit_data_w.match_start  = 32'd0;
      emit_data_w.node_now     = 8'(cur_ff);
      emit_data_w.status_code  = status_ff;
      emit_data_w.last_result  = 1'b1;

      unique case (state_ff)
         ST_INIT: begin
            cnt_we = 1'b1;
         end
         ST_IDLE: begin
            if (start) begin
               status_in = STATUS_OK;
               unique case (req_data.operation)
                  OP_CLEAR: begin
                     used_in = UW'(1);
                     cur_in  = '0;
                     pos_in  = 32'd0;
                     cnt_we  = 1'b1;
                  end
                  OP_REWIND: begin
                     cur_in = '0;
                     pos_in = 32'd0;
                  end
                  OP_ADD: begin
                     lk_node_in = cur_ff;
                     lk_sym_in  = SYM_MOD[req_data.symbol];
                     ret_in     = ST_ADD_DEC;
                  end
                  OP_CLOSE: begin
                     la_node_in = cur_ff;
                     la_len_in  = req_data.pattern_length;
                     la_ret_in  = ST_EMIT;
                  end
                  OP_BUILD: begin
                     head_in    = '0;
                     tail_in    = '0;
                     cs_in      = '0;
                     root_in    = 1'b1;
                     c_in       = '0;
                     lk_node_in = '0;
                     lk_sym_in  = '0;
                     ret_in     = ST_BL_DEC;
                  end
                  OP_SEARCH: begin
                     pos_in     = pos_ff + 32'd1;
                     lk_node_in = cur_ff;
                     lk_sym_in  = SYM_MOD[sym_fold_w];
                     ret_in     = ST_SR_DEC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_DEC: begin
            if (edge_nz) begin
               cur_in = edge_w;
            end else if (used_ff < UW'(NODE_COUNT)) begin
               alloc_en   = 1'b1;
               fail_we    = 1'b1;
               fail_waddr = used_ff[NW-1:0];
               cnt_we     = 1'b1;
               cnt_waddr  = used_ff[NW-1:0];
               cur_in     = used_ff[NW-1:0];
               used_in    = used_ff + UW'(1);
            end else begin
               status_in = STATUS_NODE_FULL;
            end
         end
         ST_SR_DEC: begin
            if (edge_nz || (lk_node_ff == '0)) begin
               cur_in = edge_w;
            end else begin
               fail_raddr = lk_node_ff;
            end
         end
         ST_SR_FAIL: begin
            cur_in     = fail_q;
            lk_node_in = fail_q;
            ret_in     = ST_SR_DEC;
         end
         ST_SR_CNT: begin
            cnt_raddr = cur_ff;
         end
         ST_SR_CNTQ: begin
            la_n_in    = cnt_q;
            la_k_in    = '0;
            mlen_raddr = {cur_ff, MW'(0)};
         end
         ST_SR_MATCH: begin
            emit_w                   = 1'b1;
            emit_data_w.match_found  = 1'b1;
            emit_data_w.match_length = mlen_q;
            emit_data_w.match_start  = pos_ff - 32'(mlen_q);
            emit_data_w.status_code  = STATUS_OK;
            emit_data_w.last_result  = (la_k1_w == la_n_ff);
            la_k_in                  = la_k1_w;
            mlen_raddr               = {cur_ff, la_k1_w[MW-1:0]};
         end
         ST_LA_CNT: begin
            cnt_raddr = la_node_ff;
         end
         ST_LA_SCAN: begin
            la_n_in    = cnt_q;
            la_k_in    = '0;
            mlen_raddr = {la_node_ff, MW'(0)};
         end
         ST_LA_CMP: begin
            if ((mlen_q != la_len_ff) && (la_k1_w != la_n_ff)) begin
               la_k_in    = la_k1_w;
               mlen_raddr = {la_node_ff, la_k1_w[MW-1:0]};
            end
         end
         ST_LA_APP: begin
            if (la_n_ff >= CW'(MATCHES_PER_NODE)) begin
               status_in = STATUS_MATCH_FULL;
            end else begin
               mlen_we    = 1'b1;
               mlen_waddr = {la_node_ff, la_n_ff[MW-1:0]};
               mlen_wdata = la_len_ff;
               cnt_we     = 1'b1;
               cnt_waddr  = la_node_ff;
               cnt_wdata  = la_n_ff + CW'(1);
            end
         end
         ST_BL_DEC: begin
            if (edge_nz) begin
               q_we    = 1'b1;
               q_waddr = tail_ff;
               q_wdata = edge_w;
               tail_in = tail_ff + NW'(1);
               nx_in   = edge_w;
               if (root_ff) begin
                  fail_we    = 1'b1;
                  fail_waddr = edge_w;
               end else begin
                  lk_node_in = csf_ff;
                  ret_in     = ST_BL_WDEC;
               end
            end
         end
         ST_BL_NEXT: begin
            if (!c_last) begin
               c_in       = c_ff + SW'(1);
               lk_node_in = cs_ff;
               lk_sym_in  = c_ff + SW'(1);
               ret_in     = ST_BL_DEC;
            end
         end
         ST_BL_POP: begin
            if (head_ff != tail_ff) begin
               q_raddr = head_ff;
               head_in = head_ff + NW'(1);
            end
         end
         ST_BL_POPQ: begin
            cs_in      = q_q;
            root_in    = 1'b0;
            fail_raddr = q_q;
         end
         ST_BL_CSF: begin
            csf_in     = fail_q;
            c_in       = '0;
            lk_node_in = cs_ff;
            lk_sym_in  = '0;
            ret_in     = ST_BL_DEC;
         end
         ST_BL_WDEC: begin
            if (edge_nz || (lk_node_ff == '0)) begin
               fail_we    = 1'b1;
               fail_waddr = nx_ff;
               fail_wdata = (edge_w == nx_ff) ? '0 : edge_w;
               t_in       = (edge_w == nx_ff) ? '0 : edge_w;
            end else begin
               fail_raddr = lk_node_ff;
            end
         end
         ST_BL_WFAIL: begin
            lk_node_in = fail_q;
            ret_in     = ST_BL_WDEC;
         end
         ST_BL_ICNT: begin
            cnt_raddr = t_ff;
         end
         ST_BL_IN: begin
            in_n_in    = cnt_q;
            in_k_in    = '0;
            mlen_raddr = {t_ff, MW'(0)};
         end
         ST_BL_ILEN: begin
            la_node_in = nx_ff;
            la_len_in  = mlen_q;
            la_ret_in  = ST_BL_IAFTER;
         end
         ST_BL_IAFTER: begin
            if (in_k1_w != in_n_ff) begin
               in_k_in    = in_k1_w;
               mlen_raddr = {t_ff, in_k1_w[MW-1:0]};
            end
         end
         ST_EMIT: begin
            emit_w = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cur_ff        <= '0;
         used_ff       <= UW'(1);
         pos_ff        <= 32'd0;
         fold_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         used_ff       <= used_in;
         pos_ff        <= pos_in;
         fold_ff       <= fold_in;
         rsp_strobe_ff <= emit_w;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      la_ret_ff   <= la_ret_in;
      status_ff   <= status_in;
      lk_node_ff  <= lk_node_in;
      lk_sym_ff   <= lk_sym_in;
      la_node_ff  <= la_node_in;
      la_len_ff   <= la_len_in;
      la_n_ff     <= la_n_in;
      la_k_ff     <= la_k_in;
      c_ff        <= c_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      cs_ff       <= cs_in;
      root_ff     <= root_in;
      csf_ff      <= csf_in;
      nx_ff       <= nx_in;
      t_ff        <= t_in;
      in_n_ff     <= in_n_in;
      in_k_ff     <= in_k_in;
      rsp_data_ff <= emit_data_w;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/core/mpbm_checker.sv -----
// ---------------------------------------------------------------------------
// Multi-pattern byte matcher port checker
// Watches the top level's ports and checks busy, result sequencing and result fields.
// ---------------------------------------------------------------------------
module mpbm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input mpbm_pkg::rsp_payload_type rsp_data
);
   import mpbm_pkg::*;

   // An accepted transfer keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted transfer");

   // Results of one operation arrive back to back.
   a_results_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_result) |=> rsp_strobe)
      else $error("gap inside a multi-result operation");

   a_mid_result_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_result) |-> busy)
      else $error("block idle while results remain");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.match_found) |->
         (rsp_data.match_length == 8'd0 && rsp_data.match_start == 32'd0 &&
          rsp_data.last_result))
      else $error("malformed empty result");

   a_match_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.match_found) |-> (rsp_data.status_code == STATUS_OK))
      else $error("match result carries an error status");

endmodule

bind multi_pattern_byte_matcher_core mpbm_checker u_mpbm_checker (.*);

// ----- sim/tb_multi_pattern_byte_matcher_core.sv -----
// ---------------------------------------------------------------------------
// Multi-pattern byte matcher core testbench
// Feeds pattern, link-build and search commands through the start/busy port,
// predicts every result with a behavioral automaton in this file and compares
// each result strobe field by field. It covers directed special cases, a full
// node store, case folding and random pattern sets mixed with noise.
// ---------------------------------------------------------------------------
module tb_multi_pattern_byte_matcher_core;
   import mpbm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int RING_DEPTH = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_payload_type req_data = '0;
   logic rsp_strobe;
   rsp_payload_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   multi_pattern_byte_matcher_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Automaton mirror.
   logic [7:0] trie_next [65536];
   logic [7:0] fail_node [256];
   logic [7:0] hit_len [1024];
   int hit_cnt [256];
   logic [7:0] walk_queue [256];
   int nodes_used;
   logic [7:0] cur_node;
   logic [31:0] text_pos;
   logic fold_upper = 1'b0;

   rsp_payload_type expect_ring [RING_DEPTH];
   int ring_wr = 0;
   int ring_rd = 0;
   int errors = 0;
   int ops_sent = 0;
   int hits_checked = 0;
   int idle_pct = 0;
   int cycles = 0;

   function automatic void expect_result(rsp_payload_type r);
      expect_ring[ring_wr % RING_DEPTH] = r;
      ring_wr++;
   endfunction

   function automatic void wipe_automaton();
      for (int i = 0; i < 65536; i++) trie_next[i] = '0;
      for (int i = 0; i < 256; i++) begin
         fail_node[i] = '0;
         hit_cnt[i] = 0;
         walk_queue[i] = '0;
      end
      for (int i = 0; i < 1024; i++) hit_len[i] = '0;
      nodes_used = 1;
      cur_node = '0;
      text_pos = '0;
   endfunction

   function automatic bit append_len(int node, logic [7:0] len);
      int n;
      n = hit_cnt[node];
      for (int k = 0; k < n; k++)
         if (hit_len[node*4+k] == len) return 1'b1;
      if (n >= MPBM_MATCHES_PER_NODE) return 1'b0;
      hit_len[node*4+n] = len;
      hit_cnt[node] = n + 1;
      return 1'b1;
   endfunction

   function automatic bit link_failures();
      int head, tail, cs, nx, fs, t, steps;
      bit full;
      head = 0;
      tail = 0;
      full = 1'b0;
      for (int c = 0; c < 256; c++) begin
         nx = trie_next[c];
         if (nx == 0 || tail >= 256) continue;
         fail_node[nx] = '0;
         walk_queue[tail++] = nx[7:0];
      end
      while (head < tail) begin
         cs = walk_queue[head++];
         for (int c = 0; c < 256; c++) begin
            nx = trie_next[cs*256+c];
            if (nx == 0 || tail >= 256) continue;
            walk_queue[tail++] = nx[7:0];
            fs = fail_node[cs];
            steps = 0;
            while (steps < 256 && fs != 0 && trie_next[fs*256+c] == 0) begin
               fs = fail_node[fs];
               steps++;
            end
            t = trie_next[fs*256+c];
            if (t == nx) t = 0;
            fail_node[nx] = t[7:0];
            for (int k = 0; k < hit_cnt[t]; k++)
               if (!append_len(nx, hit_len[t*4+k])) full = 1'b1;
         end
      end
      return full;
   endfunction

   function automatic void predict_hits(req_payload_type item);
      rsp_payload_type r;
      logic [1:0] status;
      int c, nx, steps, n;
      status = STATUS_OK;
      case (item.operation)
         OP_CLEAR: wipe_automaton();
         OP_REWIND: begin
            cur_node = '0;
            text_pos = '0;
         end
         OP_ADD: begin
            nx = trie_next[cur_node*256+item.symbol];
            if (nx != 0) begin
               cur_node = nx[7:0];
            end else if (nodes_used < MPBM_NODE_COUNT) begin
               nx = nodes_used++;
               for (int i = 0; i < 256; i++) trie_next[nx*256+i] = '0;
               fail_node[nx] = '0;
               hit_cnt[nx] = 0;
               trie_next[cur_node*256+item.symbol] = nx[7:0];
               cur_node = nx[7:0];
            end else begin
               status = STATUS_NODE_FULL;
            end
         end
         OP_CLOSE: if (!append_len(cur_node, item.pattern_length)) status = STATUS_MATCH_FULL;
         OP_BUILD: if (link_failures()) status = STATUS_MATCH_FULL;
         OP_SEARCH: begin
            c = item.symbol;
            if (fold_upper && c >= 8'h61 && c <= 8'h7A) c -= 32;
            steps = 0;
            while (steps < 256 && cur_node != 0 && trie_next[cur_node*256+c] == 0) begin
               cur_node = fail_node[cur_node];
               steps++;
            end
            cur_node = trie_next[cur_node*256+c];
            text_pos = text_pos + 1;
            n = hit_cnt[cur_node];
            if (n > 0) begin
               for (int k = 0; k < n; k++) begin
                  r.match_found = 1'b1;
                  r.match_length = hit_len[cur_node*4+k];
                  r.match_start = text_pos - 32'(hit_len[cur_node*4+k]);
                  r.node_now = cur_node;
                  r.status_code = STATUS_OK;
                  r.last_result = (k + 1 == n);
                  expect_result(r);
               end
               return;
            end
         end
         default: ;
      endcase
      r = '0;
      r.node_now = cur_node;
      r.status_code = status;
      r.last_result = 1'b1;
      expect_result(r);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) begin
         if (ring_wr == ring_rd) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            rsp_payload_type e;
            e = expect_ring[ring_rd % RING_DEPTH];
            ring_rd++;
            hits_checked++;
            if (rsp_data.match_found !== e.match_found) begin
               $error("match_found expected %0d actual %0d", e.match_found, rsp_data.match_found);
               errors++;
            end
            if (rsp_data.match_length !== e.match_length) begin
               $error("match_length expected %0d actual %0d", e.match_length,
                      rsp_data.match_length);
               errors++;
            end
            if (rsp_data.match_start !== e.match_start) begin
               $error("match_start expected %0d actual %0d", e.match_start, rsp_data.match_start);
               errors++;
            end
            if (rsp_data.node_now !== e.node_now) begin
               $error("node_now expected %0d actual %0d", e.node_now, rsp_data.node_now);
               errors++;
            end
            if (rsp_data.status_code !== e.status_code) begin
               $error("status_code expected %0d actual %0d", e.status_code, rsp_data.status_code);
               errors++;
            end
            if (rsp_data.last_result !== e.last_result) begin
               $error("last_result expected %0d actual %0d", e.last_result, rsp_data.last_result);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("multi_pattern_byte_matcher_core: mismatch");
         $finish;
      end
   end

   task automatic issue_op(logic [2:0] op, logic [7:0] sym, logic [7:0] plen);
      req_payload_type item;
      item.operation = op;
      item.symbol = sym;
      item.pattern_length = plen;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predict_hits(item);
      ops_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (ring_wr != ring_rd) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_fold(logic value);
      drain();
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 3'(CSR_FOLD_CASE) << 2;
      pwdata <= {31'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      fold_upper = value;
   endtask

   task automatic enter_pattern(string p, logic [7:0] plen);
      issue_op(OP_REWIND, 8'($urandom), 8'($urandom));
      for (int i = 0; i < p.len(); i++) issue_op(OP_ADD, p[i], 8'($urandom));
      issue_op(OP_CLOSE, 8'($urandom), plen);
   endtask

   task automatic test_classic_set();
      string text;
      text = "ushers";
      issue_op(OP_CLEAR, 8'h00, 8'h01);
      enter_pattern("he", 8'd2);
      enter_pattern("she", 8'd3);
      enter_pattern("hers", 8'd4);
      issue_op(OP_BUILD, 8'hFF, 8'hFF);
      issue_op(OP_REWIND, 8'h00, 8'h00);
      for (int i = 0; i < text.len(); i++) issue_op(OP_SEARCH, text[i], 8'h00);
   endtask

   task automatic test_special_cases();
      issue_op(OP_CLEAR, 8'hFF, 8'hFF);
      issue_op(OP_ADD, 8'h00, 8'h01);
      issue_op(OP_ADD, 8'hFF, 8'hFF);
      issue_op(OP_CLOSE, 8'h00, 8'd1);
      issue_op(OP_CLOSE, 8'h00, 8'd1);
      issue_op(OP_CLOSE, 8'h00, 8'd255);
      issue_op(OP_CLOSE, 8'h00, 8'd2);
      issue_op(OP_CLOSE, 8'h00, 8'd3);
      issue_op(OP_CLOSE, 8'h00, 8'd7);
      issue_op(OP_SPARE_LO, 8'hAA, 8'h55);
      issue_op(OP_SPARE_HI, 8'h55, 8'hAA);
      issue_op(OP_BUILD, 8'h00, 8'h00);
      issue_op(OP_REWIND, 8'h00, 8'h00);
      issue_op(OP_SEARCH, 8'hFF, 8'h00);
      issue_op(OP_SEARCH, 8'h00, 8'h00);
      issue_op(OP_SEARCH, 8'hFF, 8'h00);
   endtask

   task automatic test_fold_case();
      string text;
      text = "xAbaB";
      write_fold(1'b1);
      issue_op(OP_CLEAR, 8'h00, 8'h00);
      enter_pattern("AB", 8'd2);
      enter_pattern("B", 8'd1);
      issue_op(OP_BUILD, 8'h00, 8'h00);
      issue_op(OP_REWIND, 8'h00, 8'h00);
      for (int i = 0; i < text.len(); i++) issue_op(OP_SEARCH, text[i], 8'h00);
      write_fold(1'b0);
      for (int i = 0; i < text.len(); i++) issue_op(OP_SEARCH, text[i], 8'h00);
   endtask

   task automatic test_node_store_full();
      issue_op(OP_CLEAR, 8'h00, 8'h00);
      for (int i = 1; i < 256; i++) issue_op(OP_ADD, i[7:0], 8'($urandom));
      issue_op(OP_ADD, 8'h00, 8'h00);
      issue_op(OP_CLOSE, 8'h00, 8'd9);
      issue_op(OP_ADD, 8'hFF, 8'h00);
      issue_op(OP_CLEAR, 8'h00, 8'h00);
   endtask

   function automatic logic [7:0] pick_symbol();
      case ($urandom_range(9))
         0: return 8'h61;
         1: return 8'h62;
         2: return 8'h41;
         3: return 8'h42;
         4: return 8'h43;
         5: return 8'h00;
         6: return 8'hFF;
         7: return 8'h63;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic test_random_sets(int quota);
      int sent0, plen, tlen;
      string p;
      sent0 = ops_sent;
      while (ops_sent - sent0 < quota) begin
         issue_op(OP_CLEAR, 8'($urandom), 8'($urandom));
         for (int n = $urandom_range(1, 5); n > 0; n--) begin
            p = "";
            plen = $urandom_range(1, 4);
            for (int i = 0; i < plen; i++) p = {p, string'(pick_symbol())};
            if ($urandom_range(9) < 7) enter_pattern(p, 8'(plen));
            else enter_pattern(p, 8'($urandom_range(1, 255)));
         end
         if ($urandom_range(9) < 9) issue_op(OP_BUILD, 8'($urandom), 8'($urandom));
         issue_op(OP_REWIND, 8'($urandom), 8'($urandom));
         tlen = $urandom_range(8, 20);
         for (int i = 0; i < tlen; i++) begin
            if ($urandom_range(99) < 8)
               issue_op(3'($urandom_range(7)), 8'($urandom), 8'($urandom_range(1, 255)));
            else
               issue_op(OP_SEARCH, pick_symbol(), 8'($urandom));
         end
      end
   endtask

   initial begin
      wipe_automaton();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 10;
      test_classic_set();
      test_special_cases();
      test_fold_case();
      test_random_sets(10);
      write_fold(1'($urandom));
      idle_pct = 84;
      test_node_store_full();
      write_fold(1'b1);
      idle_pct = 0;
      test_random_sets(10);
      drain();
      $display("Sent %0d operations and checked %0d results, fold case on and off,",
               ops_sent, hits_checked);
      $display("under light, heavy and no sender idling.");
      if (errors == 0) begin
         $display("multi_pattern_byte_matcher_core: match");
      end else begin
         $display("multi_pattern_byte_matcher_core: mismatch");
      end
      $finish;
   end

endmodule
